@@ src/text_console_writer_unit_assert.svh @@
// assertion macros for the text console writer
`ifndef TEXT_CONSOLE_WRITER_UNIT_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define TCW_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define TCW_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define TCW_ASSERT(lbl, prop, msg)
`define TCW_NEVER(lbl, expr, msg)
`endif
`endif

@@ src/tcw_pkg.sv @@
// shared constants and codes for the text console writer
`timescale 1ns / 1ps
package tcw_pkg;
	localparam int DEF_COLUMNS  = 80;
	localparam int DEF_ROWS     = 25;
	localparam int DEF_TAB_STOP = 4;
	localparam int CELL_W       = 16;

	// operation codes
	localparam logic [1:0] OP_PUT   = 2'd0;
	localparam logic [1:0] OP_MOVE  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;
	localparam logic [1:0] OP_READ  = 2'd3;

	// result kinds
	localparam logic [1:0] KIND_ECHO   = 2'd0;
	localparam logic [1:0] KIND_CELL   = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	localparam logic STAT_OK     = 1'b0;
	localparam logic STAT_REJECT = 1'b1;

	// control characters
	localparam logic [7:0] CH_BS  = 8'h08;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_VT  = 8'h0B;
	localparam logic [7:0] CH_CR  = 8'h0D;

	localparam logic [7:0]        SPACE_CHAR = 8'h20;
	localparam logic [7:0]        RESET_ATTR = 8'h07;
	localparam logic [CELL_W-1:0] RESET_CELL = {RESET_ATTR, SPACE_CHAR};
endpackage

@@ src/tcw_screen_ram.sv @@
// screen cell memory, one write port and one registered read port
`timescale 1ns / 1ps
module tcw_screen_ram #(
	parameter int DEPTH  = tcw_pkg::DEF_COLUMNS * tcw_pkg::DEF_ROWS,
	parameter int ADDR_W = $clog2(DEPTH),
	parameter int DATA_W = tcw_pkg::CELL_W
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);
	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule

@@ src/text_console_writer_unit.sv @@
`timescale 1ns / 1ps
`include "text_console_writer_unit_assert.svh"
// Text console writer: a ROWS x COLUMNS screen of 16-bit cells (attribute in
// the high byte, character in the low byte) and a cursor.
// Input stream s_*: tuser carries the operation (put character, move cursor,
// clear screen, read cell); tdata carries character, row and column.
// Output stream m_*: one or two results per transaction; tuser carries the
// result kind and status, tdata the echo byte or cell, tlast marks the final
// result of a transaction. Configuration: cfg_we writes the attribute byte.
// Timing: a transaction is accepted in the idle state, the emit state loads
// its first result into the output register, and the next transaction can be
// taken once the final result is loaded and any scroll or clear is done.
// Newline and carriage return give two echo results; cell reads pass through a memory read state.
// A scroll copies the upper lines up through the single read port, then
// blanks the bottom line; a clear blanks the whole screen.
// After reset the whole memory is swept to blank cells with attribute 07;
// s_tready stays low during the sweep.
// A stalled receiver holds the result in the output register; the next
// transaction is still accepted, and its result waits until the slot frees.
module text_console_writer_unit #(
	parameter int COLUMNS  = tcw_pkg::DEF_COLUMNS,
	parameter int ROWS     = tcw_pkg::DEF_ROWS,
	parameter int TAB_STOP = tcw_pkg::DEF_TAB_STOP
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // char_code[7:0], row[13:8], col[20:14], zero pad
	input  logic [7:0]  s_tuser,   // operation[1:0], zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // data[15:0]
	output logic [7:0]  m_tuser,   // kind[1:0], status[2], zero pad
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata
);
	import tcw_pkg::*;

	localparam int CELLS   = COLUMNS * ROWS;
	localparam int COPY_N  = COLUMNS * (ROWS - 1);
	localparam int ADDR_W  = $clog2(CELLS);
	localparam int ROW_W   = $clog2(ROWS);
	localparam int COL_W   = $clog2(COLUMNS);
	localparam int NCOL_W  = $clog2(COLUMNS + TAB_STOP + 1);
	localparam int NROW_W  = $clog2(ROWS + 1);
	localparam logic [ADDR_W-1:0] COLS_A = ADDR_W'(COLUMNS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_EMIT,
		ST_EMIT2,
		ST_COPY,
		ST_FILL
	} state_t;

	state_t              state_q;
	logic [ADDR_W-1:0]   cnt_q;
	logic [CELL_W-1:0]   fill_data_q;
	logic                copy_wr_s1;
	logic [ADDR_W-1:0]   copy_addr_s1;
	logic                scroll_q;
	logic                clear_q;
	logic [1:0]          res_kind_q;
	logic [CELL_W-1:0]   res_data_q;
	logic                res_status_q;
	logic                res_two_q;
	logic [ROW_W-1:0]    cursor_row_q;
	logic [COL_W-1:0]    cursor_col_q;
	logic [7:0]          attribute_q;

	// input fields
	logic [1:0] in_op;
	logic [7:0] in_char;
	logic [5:0] in_row;
	logic [6:0] in_col;
	assign in_op   = s_tuser[1:0];
	assign in_char = s_tdata[7:0];
	assign in_row  = s_tdata[13:8];
	assign in_col  = s_tdata[20:14];

	logic accept;
	logic in_range;
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign in_range = ({1'b0, in_row} < 7'(ROWS)) && ({1'b0, in_col} < 8'(COLUMNS));

	logic [CELL_W-1:0] blank_cell;
	assign blank_cell = {attribute_q, SPACE_CHAR};

	// next tab stop for each column
	logic [NCOL_W-1:0] tab_lut [2**COL_W];
	for (genvar i = 0; i < 2**COL_W; i++) begin : g_tab
		localparam int TGT = (i / TAB_STOP + 1) * TAB_STOP;
		assign tab_lut[i] = NCOL_W'(TGT);
	end

	// cell address of the cursor or of the requested position
	logic [ROW_W-1:0]  pos_row;
	logic [COL_W-1:0]  pos_col;
	logic [ADDR_W-1:0] pos_addr;
	always_comb begin
		if (in_op == OP_PUT) begin
			pos_row = cursor_row_q;
			pos_col = cursor_col_q;
		end else begin
			pos_row = ROW_W'(in_row);
			pos_col = COL_W'(in_col);
		end
		pos_addr = ADDR_W'(pos_row) * COLS_A + ADDR_W'(pos_col);
	end

	// cursor update for put character
	logic              put_plain;
	logic [NCOL_W-1:0] ncol;
	logic [NROW_W-1:0] nrow;
	logic              put_scroll;
	logic [ROW_W-1:0]  put_row;
	logic [COL_W-1:0]  put_col;
	always_comb begin
		put_plain = 1'b0;
		ncol      = NCOL_W'(cursor_col_q);
		nrow      = NROW_W'(cursor_row_q);
		case (in_char)
			CH_LF: begin
				ncol = '0;
				nrow = nrow + NROW_W'(1);
			end
			CH_CR: begin
				ncol = '0;
			end
			CH_BS: begin
				if (cursor_col_q != '0) begin
					ncol = ncol - NCOL_W'(1);
				end
			end
			CH_VT: begin
				nrow = nrow + NROW_W'(1);
			end
			CH_TAB: begin
				ncol = tab_lut[cursor_col_q];
			end
			default: begin
				put_plain = 1'b1;
				ncol      = ncol + NCOL_W'(1);
			end
		endcase
		if (ncol >= NCOL_W'(COLUMNS)) begin
			ncol = '0;
			nrow = nrow + NROW_W'(1);
		end
		put_scroll = (nrow >= NROW_W'(ROWS));
		put_row    = put_scroll ? ROW_W'(ROWS - 1) : ROW_W'(nrow);
		put_col    = COL_W'(ncol);
	end

	// memory ports: copy write-back first, then sweep, then character write
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [CELL_W-1:0] mem_wdata;
	logic [ADDR_W-1:0] mem_raddr;
	logic [CELL_W-1:0] mem_rdata;
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = pos_addr;
		mem_wdata = {attribute_q, in_char};
		if (copy_wr_s1) begin
			mem_we    = 1'b1;
			mem_waddr = copy_addr_s1;
			mem_wdata = mem_rdata;
		end else if (state_q == ST_FILL) begin
			mem_we    = 1'b1;
			mem_waddr = cnt_q;
			mem_wdata = fill_data_q;
		end else if (accept && in_op == OP_PUT && put_plain) begin
			mem_we = 1'b1;
		end
		mem_raddr = (state_q == ST_COPY) ? cnt_q + COLS_A : pos_addr;
	end

	tcw_screen_ram #(
		.DEPTH (CELLS),
		.ADDR_W(ADDR_W),
		.DATA_W(CELL_W)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// where to go once the last result is in the output register
	state_t after_st;
	logic   out_free;
	logic   out_load;
	always_comb begin
		if (scroll_q) begin
			after_st = ST_COPY;
		end else if (clear_q) begin
			after_st = ST_FILL;
		end else begin
			after_st = ST_IDLE;
		end
		out_free = !m_tvalid || m_tready;
		out_load = ((state_q == ST_EMIT) || (state_q == ST_EMIT2)) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attribute_q <= RESET_ATTR;
		end else if (cfg_we) begin
			attribute_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_FILL;
			cnt_q        <= '0;
			fill_data_q  <= RESET_CELL;
			copy_wr_s1   <= 1'b0;
			copy_addr_s1 <= '0;
			scroll_q     <= 1'b0;
			clear_q      <= 1'b0;
			res_kind_q   <= KIND_STATUS;
			res_data_q   <= '0;
			res_status_q <= STAT_OK;
			res_two_q    <= 1'b0;
			cursor_row_q <= '0;
			cursor_col_q <= '0;
			m_tvalid     <= 1'b0;
			m_tdata      <= '0;
			m_tuser      <= '0;
			m_tlast      <= 1'b0;
		end else begin
			copy_wr_s1 <= 1'b0;
			if (out_load) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						res_kind_q   <= KIND_STATUS;
						res_data_q   <= '0;
						res_status_q <= STAT_OK;
						res_two_q    <= 1'b0;
						state_q      <= ST_EMIT;
						unique case (in_op)
							OP_PUT: begin
								cursor_row_q <= put_row;
								cursor_col_q <= put_col;
								scroll_q     <= put_scroll;
								if (in_char == CH_LF || in_char == CH_CR) begin
									res_kind_q <= KIND_ECHO;
									res_data_q <= {8'h00, CH_LF};
									res_two_q  <= 1'b1;
								end else if (put_plain) begin
									res_kind_q <= KIND_ECHO;
									res_data_q <= {8'h00, in_char};
								end
							end
							OP_MOVE: begin
								if (in_range) begin
									cursor_row_q <= pos_row;
									cursor_col_q <= pos_col;
								end else begin
									res_status_q <= STAT_REJECT;
								end
							end
							OP_CLEAR: begin
								clear_q <= 1'b1;
							end
							OP_READ: begin
								if (in_range) begin
									state_q <= ST_READ;
								end else begin
									res_status_q <= STAT_REJECT;
								end
							end
							default: ;
						endcase
					end
				end
				ST_READ: begin
					res_kind_q <= KIND_CELL;
					res_data_q <= mem_rdata;
					state_q    <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						m_tdata  <= res_data_q;
						m_tuser  <= {5'b0, res_status_q, res_kind_q};
						m_tlast  <= !res_two_q;
						if (res_two_q) begin
							state_q <= ST_EMIT2;
						end else begin
							state_q     <= after_st;
							cnt_q       <= '0;
							fill_data_q <= blank_cell;
						end
					end
				end
				ST_EMIT2: begin
					if (out_free) begin
						m_tdata     <= {8'h00, CH_CR};
						m_tuser     <= {5'b0, STAT_OK, KIND_ECHO};
						m_tlast     <= 1'b1;
						state_q     <= after_st;
						cnt_q       <= '0;
						fill_data_q <= blank_cell;
					end
				end
				ST_COPY: begin
					// read one line below now, write it back next cycle
					copy_wr_s1   <= 1'b1;
					copy_addr_s1 <= cnt_q;
					if (cnt_q == ADDR_W'(COPY_N - 1)) begin
						state_q     <= ST_FILL;
						fill_data_q <= blank_cell;
					end
					cnt_q <= cnt_q + ADDR_W'(1);
				end
				ST_FILL: begin
					// wait while the last copy write holds the port
					if (!copy_wr_s1) begin
						if (cnt_q == ADDR_W'(CELLS - 1)) begin
							state_q  <= ST_IDLE;
							scroll_q <= 1'b0;
							clear_q  <= 1'b0;
						end else begin
							cnt_q <= cnt_q + ADDR_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`TCW_NEVER(a_ready_during_copy, s_tready && copy_wr_s1, "transaction taken while copy pending")
	`TCW_NEVER(a_cursor_range, ({1'b0, cursor_row_q} >= (ROW_W+1)'(ROWS)) || ({1'b0, cursor_col_q} >= (COL_W+1)'(COLUMNS)), "cursor out of range")
	`TCW_ASSERT(a_first_echo_not_last, (state_q == ST_EMIT2 && m_tvalid) |-> !m_tlast, "first of two results marked last")
	`TCW_ASSERT(a_copy_addr, copy_wr_s1 |-> ({1'b0, copy_addr_s1} < (ADDR_W+1)'(COPY_N)), "copy write beyond upper lines")
	`TCW_ASSERT(a_sweep_addr, (state_q == ST_FILL) |-> ({1'b0, cnt_q} < (ADDR_W+1)'(CELLS)), "sweep beyond screen")
endmodule
